// File: rtl/iab_pkg.sv
// Shared types, constants and step-size table for the IMA-ADPCM block encoder.
package iab_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int CFG_W             = 13;
  localparam int MAX_BLOCK_LEN_DEF = 4096;
  localparam int STEP_TABLE_LEN    = 89;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam logic [CFG_W-1:0] BLOCK_LEN_RESET = 13'd128;
  localparam logic [6:0]       STEP_MAX        = 7'(STEP_TABLE_LEN - 1);

  localparam logic [14:0] STEP_SIZES [STEP_TABLE_LEN] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  // How the back end treats an item
  typedef enum logic [1:0] {
    KIND_HEADER,  // raw sample, two bytes plus step index
    KIND_SOLO,    // code alone in the low nibble
    KIND_HOLD,    // code kept for the next byte
    KIND_PAIR     // code in the high nibble over the held one
  } kind_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD
  } phase_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    kind_t                      kind;
    logic                       block_end;
  } mid_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       block_end;
  } out_item_t;

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] val;
    val = 15'd32767;
    if (idx <= STEP_MAX) begin
      val = STEP_SIZES[idx];
    end
    return val;
  endfunction

endpackage

// File: rtl/ima_adpcm_block_encoder.sv
// Top level of the IMA-ADPCM block encoder.
//
//   channel       handshake                    payload
//   samples in    push / full                  sample
//   bytes out     pop / empty                  out_byte, run_last, block_end
//   block length  block_length_valid / _ready  block_length
//
// In the back end a header sample is sent one byte per phase; a code sample first
// takes magnitude and step lookup, then is quantised and updates the predictor.
// That predictor/step-index loop in the back end sets the sustained rate.
// Reset is synchronous and clears both queues, position, predictor and step index.
// Samples are taken while the inner queue has room; a full output queue stalls
// only the back end.
module ima_adpcm_block_encoder #(
  parameter int MAX_BLOCK_LEN = iab_pkg::MAX_BLOCK_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic signed [iab_pkg::SAMPLE_W-1:0] sample,
  output logic                                full,
  input  logic                                pop,
  output logic                                empty,
  output logic [7:0]                          out_byte,
  output logic                                run_last,
  output logic                                block_end,
  input  logic                                block_length_valid,
  output logic                                block_length_ready,
  input  logic [iab_pkg::CFG_W-1:0]           block_length
);
  import iab_pkg::*;

  localparam int MID_W = $bits(mid_item_t);
  localparam int OUT_W = $bits(out_item_t);

  logic             mid_push;
  mid_item_t        mid_din;
  logic             mid_full;
  logic             mid_pop;
  logic [MID_W-1:0] mid_dout_bits;
  mid_item_t        mid_dout;
  logic             mid_empty;
  logic             out_push;
  out_item_t        out_din;
  logic             out_full;
  logic [OUT_W-1:0] out_dout_bits;
  out_item_t        out_dout;

  iab_front #(
    .MAX_BLOCK_LEN(MAX_BLOCK_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(block_length_valid),
    .cfg_data (block_length),
    .cfg_ready(block_length_ready),
    .push     (push),
    .sample   (sample),
    .full     (full),
    .mid_push (mid_push),
    .mid_din  (mid_din),
    .mid_full (mid_full)
  );

  iab_fifo #(
    .WIDTH(MID_W),
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (mid_push),
    .din  (mid_din),
    .full (mid_full),
    .pop  (mid_pop),
    .dout (mid_dout_bits),
    .empty(mid_empty)
  );

  assign mid_dout = mid_item_t'(mid_dout_bits);

  iab_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_dout (mid_dout),
    .mid_empty(mid_empty),
    .mid_pop  (mid_pop),
    .out_push (out_push),
    .out_din  (out_din),
    .out_full (out_full)
  );

  iab_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .din  (out_din),
    .full (out_full),
    .pop  (pop),
    .dout (out_dout_bits),
    .empty(empty)
  );

  assign out_dout  = out_item_t'(out_dout_bits);
  assign out_byte  = out_dout.out_byte;
  assign run_last  = out_dout.run_last;
  assign block_end = out_dout.block_end;

endmodule

// File: rtl/iab_fifo.sv
// Small first-in first-out queue used between the encoder stages.
module iab_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// File: rtl/iab_front.sv
// Front end: block length register, sample position tracking and item classification.
module iab_front #(
  parameter int MAX_BLOCK_LEN = iab_pkg::MAX_BLOCK_LEN_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [iab_pkg::CFG_W-1:0]              cfg_data,
  output logic                                   cfg_ready,
  input  logic                                   push,
  input  logic signed [iab_pkg::SAMPLE_W-1:0]    sample,
  output logic                                   full,
  output logic                                   mid_push,
  output iab_pkg::mid_item_t                     mid_din,
  input  logic                                   mid_full
);
  import iab_pkg::*;

  localparam int PW = $clog2(MAX_BLOCK_LEN);
  localparam int LW = $clog2(MAX_BLOCK_LEN + 1);
  localparam int EW = (LW > CFG_W) ? LW : CFG_W;

  logic [CFG_W-1:0] blen;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    pos_next;
  logic [EW-1:0]    blen_x;
  logic [EW-1:0]    eff;
  logic [EW:0]      pos_plus;
  logic             last;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign full      = mid_full;
  assign accept    = push && !mid_full;
  assign mid_push  = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      blen <= BLOCK_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      blen <= cfg_data;
    end
  end

  always_comb begin
    blen_x   = EW'(blen);
    if (blen_x < EW'(2)) begin
      eff = EW'(2);
    end else if (blen_x > EW'(MAX_BLOCK_LEN)) begin
      eff = EW'(MAX_BLOCK_LEN);
    end else begin
      eff = blen_x;
    end
    pos_plus = (EW+1)'(pos) + (EW+1)'(1);
    last     = (pos_plus >= {1'b0, eff});
    pos_next = last ? '0 : PW'(pos_plus);
  end

  always_comb begin
    mid_din.sample    = sample;
    mid_din.block_end = last;
    if (pos == '0) begin
      mid_din.kind      = KIND_HEADER;
      mid_din.block_end = 1'b0;
    end else if (pos == PW'(1)) begin
      mid_din.kind = KIND_SOLO;
    end else if (!pos[0]) begin
      mid_din.kind = last ? KIND_SOLO : KIND_HOLD;
    end else begin
      mid_din.kind = KIND_PAIR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

endmodule

// File: rtl/iab_back.sv
// Back end: ADPCM quantiser, predictor and step index state, and byte packing.
module iab_back (
  input  logic               clk,
  input  logic               rst,
  input  iab_pkg::mid_item_t mid_dout,
  input  logic               mid_empty,
  output logic               mid_pop,
  output logic               out_push,
  output iab_pkg::out_item_t out_din,
  input  logic               out_full
);
  import iab_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  logic               cur_valid;
  mid_item_t          cur;
  logic [15:0]        mag;
  logic               neg;
  logic [14:0]        step;
  logic signed [15:0] pred;
  logic [6:0]         step_pos;
  logic [3:0]         held;

  logic               finish;
  logic               take;
  logic               prep;
  logic               commit;
  logic               seed;

  logic signed [16:0] diff;
  logic [16:0]        d1;
  logic [16:0]        d2;
  logic [14:0]        st1;
  logic [14:0]        st2;
  logic               b2;
  logic               b1;
  logic               b0;
  logic [15:0]        vpdiff;
  logic [3:0]         code;
  logic signed [17:0] pred_sum;
  logic signed [15:0] pred_new;
  logic [7:0]         sp_up;
  logic [6:0]         sp_new;

  // Quantiser, three successive approximation steps
  always_comb begin
    diff   = 17'(cur.sample) - 17'(pred);
    st1    = step >> 1;
    st2    = step >> 2;
    b2     = ({1'b0, mag} >= 17'(step));
    d1     = b2 ? {1'b0, mag} - 17'(step) : {1'b0, mag};
    b1     = (d1 >= 17'(st1));
    d2     = b1 ? d1 - 17'(st1) : d1;
    b0     = (d2 >= 17'(st2));
    vpdiff = 16'(step >> 3) + (b2 ? 16'(step) : 16'd0) + (b1 ? 16'(st1) : 16'd0)
           + (b0 ? 16'(st2) : 16'd0);
    code   = {neg, b2, b1, b0};
    pred_sum = neg ? 18'(pred) - 18'(vpdiff) : 18'(pred) + 18'(vpdiff);
    if (pred_sum > 18'sd32767) begin
      pred_new = 16'sh7FFF;
    end else if (pred_sum < -18'sd32768) begin
      pred_new = 16'sh8000;
    end else begin
      pred_new = 16'(pred_sum);
    end
    sp_up = {1'b0, step_pos} + {5'd0, code[1:0], 1'b0} + 8'd2;
    if (!code[2]) begin
      sp_new = (step_pos == '0) ? '0 : step_pos - 7'd1;
    end else if (sp_up > {1'b0, STEP_MAX}) begin
      sp_new = STEP_MAX;
    end else begin
      sp_new = 7'(sp_up);
    end
  end

  always_comb begin
    phase_next = phase;
    finish     = 1'b0;
    prep       = 1'b0;
    commit     = 1'b0;
    seed       = 1'b0;
    out_push   = 1'b0;
    out_din    = '{out_byte: 8'd0, run_last: 1'b0, block_end: 1'b0};
    if (cur_valid) begin
      if (cur.kind == KIND_HEADER) begin
        if (!out_full) begin
          out_push = 1'b1;
          unique case (phase)
            PH_FIRST: begin
              out_din.out_byte = cur.sample[7:0];
              phase_next       = PH_SECOND;
            end
            PH_SECOND: begin
              out_din.out_byte = cur.sample[15:8];
              phase_next       = PH_THIRD;
            end
            PH_THIRD: begin
              out_din.out_byte = {1'b0, step_pos};
              out_din.run_last = 1'b1;
              seed             = 1'b1;
              finish           = 1'b1;
              phase_next       = PH_FIRST;
            end
            default: begin
              out_push   = 1'b0;
              phase_next = PH_FIRST;
            end
          endcase
        end
      end else if (phase == PH_FIRST) begin
        prep       = 1'b1;
        phase_next = PH_SECOND;
      end else if (cur.kind == KIND_HOLD || !out_full) begin
        commit     = 1'b1;
        finish     = 1'b1;
        phase_next = PH_FIRST;
        out_push   = (cur.kind != KIND_HOLD);
        out_din.run_last  = 1'b1;
        out_din.block_end = cur.block_end;
        out_din.out_byte  = (cur.kind == KIND_PAIR) ? {code, held} : {4'd0, code};
      end
    end
  end

  assign take    = !cur_valid || finish;
  assign mid_pop = take && !mid_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pred      <= '0;
      step_pos  <= '0;
      held      <= '0;
    end else begin
      if (take) begin
        cur_valid <= !mid_empty;
      end
      if (seed) begin
        pred <= cur.sample;
      end else if (commit) begin
        pred     <= pred_new;
        step_pos <= sp_new;
        if (cur.kind == KIND_HOLD) begin
          held <= code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      cur <= mid_dout;
    end
    if (prep) begin
      neg  <= diff[16];
      mag  <= diff[16] ? 16'(-diff) : 16'(diff);
      step <= step_size(step_pos);
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_pos <= STEP_MAX)
    else $error("step index beyond table");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_push && out_din.block_end |-> out_din.run_last)
    else $error("block end on a byte that is not the last of its sample");

  a_code_phases: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur.kind != KIND_HEADER |-> phase != PH_THIRD)
    else $error("code item reached header-only phase");

  a_hold_silent: assert property (@(posedge clk) disable iff (rst)
    commit && cur.kind == KIND_HOLD |-> !out_push)
    else $error("held nibble emitted a byte");

endmodule

// File: verif/ima_adpcm_block_encoder_test.sv
// Self-checking testbench for the IMA-ADPCM block encoder: queue-fed driver, checking monitor.
`timescale 1ns / 1ps

module ima_adpcm_block_encoder_test;
  import iab_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int CHOKE_CYCLES = 300;
  localparam int IDX_MOVES [16] = '{-1, -1, -1, -1, 2, 4, 6, 8,
                                    -1, -1, -1, -1, 2, 4, 6, 8};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic full;
  logic pop = 1'b0;
  logic empty;
  logic [7:0] out_byte;
  logic run_last;
  logic block_end;
  logic block_length_valid = 1'b0;
  logic block_length_ready;
  logic [CFG_W-1:0] block_length = BLOCK_LEN_RESET;

  ima_adpcm_block_encoder uut (
    .clk(clk), .rst(rst),
    .push(push), .sample(sample), .full(full),
    .pop(pop), .empty(empty),
    .out_byte(out_byte), .run_last(run_last), .block_end(block_end),
    .block_length_valid(block_length_valid), .block_length_ready(block_length_ready),
    .block_length(block_length)
  );

  // encoder state as predicted
  logic [CFG_W-1:0] blk_len = BLOCK_LEN_RESET;
  logic signed [15:0] pred_val = '0;
  logic [6:0] step_idx = '0;
  logic [11:0] smp_pos = '0;
  logic [3:0] held_code = '0;

  logic [15:0] pending_samples [$];
  out_item_t awaited_bytes [$];

  bit calm = 1'b0;
  bit choke_req = 1'b0;
  bit choke_seen = 1'b0;
  int choke_left = 0;
  int quiet = 0;
  int err_count = 0;
  int samples_sent = 0;
  int bytes_seen = 0;
  int blocks_seen = 0;
  int cfg_writes = 0;
  int walk = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic logic [3:0] adpcm_code(input logic signed [15:0] s);
    int diff, step, vpdiff, p, idx, b;
    logic [3:0] code;
    diff = int'(s) - int'(pred_val);
    step = int'(STEP_SIZES[step_idx]);
    vpdiff = step >>> 3;
    code = 4'h0;
    if (diff < 0) begin
      code[3] = 1'b1;
      diff = -diff;
    end
    for (b = 2; b >= 0; b--) begin
      if (diff >= step) begin
        code[b] = 1'b1;
        diff -= step;
        vpdiff += step;
      end
      step = step >>> 1;
    end
    p = code[3] ? int'(pred_val) - vpdiff : int'(pred_val) + vpdiff;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    pred_val = p[15:0];
    idx = int'(step_idx) + IDX_MOVES[code];
    if (idx < 0) idx = 0;
    if (idx > STEP_TABLE_LEN - 1) idx = STEP_TABLE_LEN - 1;
    step_idx = idx[6:0];
    return code;
  endfunction

  task automatic predict_bytes(input logic [15:0] raw);
    int eff;
    bit last;
    logic [3:0] code;
    eff = int'(blk_len);
    if (eff < 2) eff = 2;
    if (eff > MAX_BLOCK_LEN_DEF) eff = MAX_BLOCK_LEN_DEF;
    last = (int'(smp_pos) + 1 >= eff);
    if (smp_pos == 0) begin
      pred_val = raw;
      awaited_bytes.push_back(out_item_t'({raw[7:0], 1'b0, 1'b0}));
      awaited_bytes.push_back(out_item_t'({raw[15:8], 1'b0, 1'b0}));
      awaited_bytes.push_back(out_item_t'({1'b0, step_idx, 1'b1, 1'b0}));
    end else begin
      code = adpcm_code(raw);
      if (smp_pos == 1) begin
        awaited_bytes.push_back(out_item_t'({4'h0, code, 1'b1, last}));
      end else if (!smp_pos[0]) begin
        if (last) begin
          awaited_bytes.push_back(out_item_t'({4'h0, code, 1'b1, 1'b1}));
        end else begin
          held_code = code;
        end
      end else begin
        awaited_bytes.push_back(out_item_t'({code, held_code, 1'b1, last}));
      end
    end
    smp_pos = last ? 12'd0 : smp_pos + 12'd1;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_bytes(sample);
        samples_sent++;
        void'(pending_samples.pop_front());
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
        push <= 1'b1;
        sample <= pending_samples[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        bytes_seen++;
        if (block_end) blocks_seen++;
        if (awaited_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing awaited", out_byte));
        end else begin
          want = awaited_bytes.pop_front();
          if (out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.out_byte));
          if (run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b", run_last, want.run_last));
          if (block_end !== want.block_end)
            report_mismatch($sformatf("block_end %b, want %b", block_end, want.block_end));
        end
      end
      if (choke_req && !choke_seen) begin
        choke_seen = 1'b1;
        choke_left = CHOKE_CYCLES;
      end
      if (choke_left > 0) begin
        choke_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (block_length_valid && block_length_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("[ima_adpcm_block_encoder] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_length(input logic [CFG_W-1:0] len);
    @(posedge clk);
    block_length_valid <= 1'b1;
    block_length <= len;
    do @(posedge clk); while (!block_length_ready);
    block_length_valid <= 1'b0;
    blk_len = len;
    cfg_writes++;
  endtask

  task automatic drain;
    while (pending_samples.size() > 0 || awaited_bytes.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] audio_sample();
    int pick;
    pick = $urandom_range(9);
    if (pick <= 5) begin
      walk += $urandom_range(2000) - 1000;
      if (walk > 32767) walk = 32767;
      if (walk < -32768) walk = -32768;
    end else if (pick <= 7) begin
      walk = int'($signed(16'($urandom())));
    end else if (pick == 8) begin
      case ($urandom_range(2))
        0: walk = 32767;
        1: walk = -32768;
        default: walk = 0;
      endcase
    end
    return walk[15:0];
  endfunction

  task automatic random_phase(input logic [CFG_W-1:0] len, input int n);
    write_length(len);
    @(negedge clk);
    repeat (n) pending_samples.push_back(audio_sample());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // length zero acts as two: header plus one solo code per block
    write_length(13'd0);
    @(negedge clk);
    pending_samples = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
    drain();

    // length three: odd tail every block, step index driven up in large steps
    write_length(13'd3);
    @(negedge clk);
    pending_samples = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001,
                        16'hFFFF, 16'h8000};
    drain();

    // length six: full pairs, then flat input walks the step index down
    write_length(13'd6);
    @(negedge clk);
    pending_samples = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h1234, 16'h1234,
                        16'h1234, 16'h1234, 16'h1234, 16'h1234};
    drain();

    random_phase(13'd1, 30);

    @(negedge clk);
    calm = 1'b1;
    random_phase(13'($urandom_range(2, 12)), 40);
    @(negedge clk);
    calm = 1'b0;

    // receiver holds off while the sender keeps offering
    write_length(13'h1FFF);
    @(negedge clk);
    choke_req = 1'b1;
    repeat (40) pending_samples.push_back(audio_sample());
    drain();

    // lowered well below the current position: next sample closes the block
    random_phase(13'd4, 20);
    random_phase(13'd4096, 20);
    random_phase(13'd4095, 10);
    repeat (4) random_phase(13'($urandom_range(2, 20)), 20);

    $display("covered %0d samples, %0d bytes, %0d block ends over %0d length settings",
             samples_sent, bytes_seen, blocks_seen, cfg_writes);
    $display("%0d mismatches", err_count);
    if (err_count == 0) begin
      $display("[ima_adpcm_block_encoder] OK");
    end else begin
      $display("[ima_adpcm_block_encoder] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/iab_pkg.sv
rtl/iab_fifo.sv
rtl/iab_front.sv
rtl/iab_back.sv
rtl/ima_adpcm_block_encoder.sv
verif/ima_adpcm_block_encoder_test.sv
